[hw/rtl/lbrw_pkg.sv]
// Shared types and constants for the longest bounded-range window block.
package lbrw_pkg;

  localparam int SAMPLE_W = 16;
  localparam int LEN_W = 11;
  localparam int WINDOW_DEPTH_DEF = 1024;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                start_new;
  } in_t;

  typedef struct packed {
    logic [LEN_W-1:0] window_length;
    logic [LEN_W-1:0] best_length;
    logic             capped;
  } out_t;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic eval;
    logic scan;
    logic commit;
  } ctrl_t;

endpackage

[hw/rtl/longest_bounded_range_window_core.sv]
// Top level of the longest bounded-range window block.
// The result of a word follows from kept, the number of stored samples that
// stay in the window (0 up to WINDOW_DEPTH): on acceptance every cell compares
// its stored sample with the new one at once, then the out-of-range flags shift
// toward the head of the cell chain one cell per cycle until the first flag, or
// the end of the current window, reaches it. The next word can be taken in the
// same cycle as the result appears. A finished result sits in an output
// register, so the next word can be taken while it waits; the result of that
// next word is held back until the waiting one has been taken.
// The reported lengths are the low 11 bits of the true lengths.
module longest_bounded_range_window_core #(
  parameter int WINDOW_DEPTH = lbrw_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lbrw_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lbrw_pkg::out_t                out_data,
  input  logic                          cfg_we,
  input  logic [lbrw_pkg::SAMPLE_W-1:0] cfg_data
);

  localparam int LW = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t                        state_r, state_nxt;
  logic [lbrw_pkg::SAMPLE_W-1:0] limit_r;
  logic [lbrw_pkg::SAMPLE_W-1:0] x_r;
  logic                          restart_r;
  logic [LW-1:0]                 cur_len_r;
  logic [LW-1:0]                 best_r;
  logic [LW-1:0]                 scan_lim_r;
  logic [LW-1:0]                 kept_r;
  logic                          out_valid_r;
  lbrw_pkg::out_t                out_r;

  lbrw_pkg::ctrl_t               ctrl;
  logic                          accept;
  logic                          scan_end;
  logic [LW:0]                   new_len_w;
  logic                          capped;
  logic [LW-1:0]                 new_len;
  logic [LW-1:0]                 base_best;
  logic [LW-1:0]                 new_best;

  logic [lbrw_pkg::SAMPLE_W-1:0] sample_w [WINDOW_DEPTH];
  logic                          flag_w [WINDOW_DEPTH];

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // The scan stops at the first out-of-range sample or at the window's end.
  assign scan_end = (kept_r == scan_lim_r) || flag_w[0];

  assign ctrl = '{
    eval:   accept,
    scan:   (state_r == ST_SCAN) && !scan_end,
    commit: (state_r == ST_SCAN) && scan_end && (!out_valid_r || out_ready)
  };

  assign new_len_w = {1'b0, kept_r} + (LW+1)'(1);
  assign capped    = new_len_w > (LW+1)'(WINDOW_DEPTH);
  assign new_len   = capped ? LW'(WINDOW_DEPTH) : new_len_w[LW-1:0];
  assign base_best = restart_r ? '0 : best_r;
  assign new_best  = (new_len > base_best) ? new_len : base_best;

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW_DEPTH; gi++) begin : g_cell
      logic [lbrw_pkg::SAMPLE_W-1:0] s_in;
      logic                          f_in;
      if (gi == 0) begin : g_head
        assign s_in = x_r;
      end else begin : g_body
        assign s_in = sample_w[gi-1];
      end
      if (gi == WINDOW_DEPTH - 1) begin : g_tail
        assign f_in = 1'b0;
      end else begin : g_mid
        assign f_in = flag_w[gi+1];
      end
      lbrw_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .cmp_sample (in_data.sample),
        .limit      (limit_r),
        .sample_in  (s_in),
        .flag_in    (f_in),
        .sample_out (sample_w[gi]),
        .flag_out   (flag_w[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ctrl.commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= '0;
      cur_len_r   <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
      if (ctrl.commit) begin
        cur_len_r   <= new_len;
        best_r      <= new_best;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r        <= in_data.sample;
      restart_r  <= in_data.start_new;
      scan_lim_r <= in_data.start_new ? '0 : cur_len_r;
      kept_r     <= '0;
    end else if (ctrl.scan) begin
      kept_r <= kept_r + LW'(1);
    end
    if (ctrl.commit) begin
      out_r.window_length <= lbrw_pkg::LEN_W'(new_len);
      out_r.best_length   <= lbrw_pkg::LEN_W'(new_best);
      out_r.capped        <= capped;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hw/rtl/lbrw_cell.sv]
// One cell of the sample chain: a stored sample and its out-of-range flag.
module lbrw_cell (
  input  logic                           clk,
  input  lbrw_pkg::ctrl_t                ctrl,
  input  logic [lbrw_pkg::SAMPLE_W-1:0]  cmp_sample,
  input  logic [lbrw_pkg::SAMPLE_W-1:0]  limit,
  input  logic [lbrw_pkg::SAMPLE_W-1:0]  sample_in,
  input  logic                           flag_in,
  output logic [lbrw_pkg::SAMPLE_W-1:0]  sample_out,
  output logic                           flag_out
);

  logic [lbrw_pkg::SAMPLE_W-1:0] sample_r;
  logic                          flag_r;
  logic [lbrw_pkg::SAMPLE_W-1:0] diff;

  always_comb begin
    if (cmp_sample >= sample_r) begin
      diff = cmp_sample - sample_r;
    end else begin
      diff = sample_r - cmp_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      sample_r <= sample_in;
    end
    // The flags march toward the head of the chain one cell per cycle.
    if (ctrl.eval) begin
      flag_r <= (diff > limit);
    end else if (ctrl.scan) begin
      flag_r <= flag_in;
    end
  end

  assign sample_out = sample_r;
  assign flag_out   = flag_r;

endmodule

[dv/longest_bounded_range_window_core_tb.sv]
// Self-checking testbench for the longest bounded-range window core.
module longest_bounded_range_window_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH    = lbrw_pkg::WINDOW_DEPTH_DEF;
  localparam int SAMPLE_W = lbrw_pkg::SAMPLE_W;
  localparam int LEN_W    = lbrw_pkg::LEN_W;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  lbrw_pkg::in_t       in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  lbrw_pkg::out_t      out_data;
  logic                cfg_we = 1'b0;
  logic [SAMPLE_W-1:0] cfg_data = '0;

  // Words waiting to be offered, and window results still owed by the block.
  lbrw_pkg::in_t  sample_queue[$];
  lbrw_pkg::out_t expected_lengths[$];

  // Shadow of the block state used to predict each result.
  logic [SAMPLE_W-1:0] kept_samples[DEPTH];
  int unsigned         ring_head = 0;
  int unsigned         run_length = 0;
  int unsigned         best_run = 0;
  logic [SAMPLE_W-1:0] range_limit_model = '0;

  // While set, neither side inserts idle cycles.
  logic steady = 1'b0;
  int   error_count = 0;

  longest_bounded_range_window_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Walk back from the newest stored sample until one lies out of range,
  // then store the new sample and report the lengths.
  function automatic lbrw_pkg::out_t advance_window(lbrw_pkg::in_t w);
    int unsigned    held;
    int unsigned    slot;
    int unsigned    gap;
    int unsigned    new_len;
    lbrw_pkg::out_t r;
    if (w.start_new) begin
      run_length = 0;
      best_run = 0;
    end
    held = 0;
    while (held < run_length) begin
      slot = (ring_head + DEPTH - 1 - held) % DEPTH;
      gap = (w.sample > kept_samples[slot]) ? w.sample - kept_samples[slot]
                                            : kept_samples[slot] - w.sample;
      if (gap > range_limit_model) break;
      held++;
    end
    new_len = held + 1;
    r.capped = 1'b0;
    if (new_len > DEPTH) begin
      new_len = DEPTH;
      r.capped = 1'b1;
    end
    kept_samples[ring_head] = w.sample;
    ring_head = (ring_head + 1) % DEPTH;
    run_length = new_len;
    if (new_len > best_run) best_run = new_len;
    r.window_length = run_length[LEN_W-1:0];
    r.best_length = best_run[LEN_W-1:0];
    return r;
  endfunction

  // Sender: the prediction is made when the block takes the word.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_lengths = {expected_lengths, advance_window(in_data)};
      if (!in_valid || in_ready) begin
        if (sample_queue.size() != 0 && (steady || $urandom_range(99) >= 12)) begin
          in_data <= sample_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each result with the oldest prediction.
  always @(posedge clk) begin
    lbrw_pkg::out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_lengths.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected result: window %0d best %0d capped %0d",
                     out_data.window_length, out_data.best_length, out_data.capped);
        end else begin
          want = expected_lengths.pop_front();
          if (out_data !== want) begin
            error_count++;
            if (error_count <= 10)
              $display("mismatch (exp/got): window %0d/%0d best %0d/%0d capped %0d/%0d",
                       want.window_length, out_data.window_length,
                       want.best_length, out_data.best_length,
                       want.capped, out_data.capped);
          end
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 12);
    end
  end

  task automatic queue_word(input logic [SAMPLE_W-1:0] value, input logic restart);
    lbrw_pkg::in_t w;
    w.sample = value;
    w.start_new = restart;
    sample_queue = {sample_queue, w};
  endtask

  // Waits until every queued word has been sent and every outstanding result has come out.
  task automatic wait_drained();
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_valid || expected_lengths.size() != 0);
  endtask

  task automatic set_range_limit(input logic [SAMPLE_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    range_limit_model = value;
    @(negedge clk);
  endtask

  // Short sequences of samples drawn from a band slightly wider than the
  // limit, so windows grow and break often, with some random noise mixed in.
  task automatic queue_banded(input int unsigned count);
    int unsigned spread;
    int unsigned base;
    int unsigned run;
    int unsigned n;
    spread = range_limit_model + range_limit_model / 2 + 1;
    if (spread > 65535) spread = 65535;
    n = 0;
    while (n < count) begin
      run = $urandom_range(60, 1);
      base = $urandom_range(65535 - spread, 0);
      for (int unsigned i = 0; i < run && n < count; i++) begin
        if ($urandom_range(7) == 0)
          queue_word(SAMPLE_W'($urandom_range(65535, 0)), $urandom_range(7) == 0);
        else
          queue_word(SAMPLE_W'(base + $urandom_range(spread, 0)), i == 0);
        n++;
      end
    end
  endtask

  initial begin
    logic [SAMPLE_W-1:0] limits[10];
    limits = '{16'h0000, 16'h0001, 16'h00FF, 16'h0FFF, 16'hFFFE,
               16'hFFFF, 16'h0003, 16'h0000, 16'h0000, 16'h8000};
    limits[7] = SAMPLE_W'($urandom_range(65535, 0));
    limits[8] = SAMPLE_W'($urandom_range(255, 0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Limit left at its reset value of zero: only equal samples stay.
    queue_word(16'h0000, 1'b0);
    queue_word(16'h0000, 1'b0);
    queue_word(16'h0000, 1'b0);
    queue_word(16'hFFFF, 1'b0);
    queue_word(16'hFFFF, 1'b0);
    queue_word(16'h0000, 1'b1);
    queue_word(16'h8000, 1'b0);
    queue_word(16'h7FFF, 1'b0);
    wait_drained();

    set_range_limit(16'hFFFF);
    queue_word(16'hFFFF, 1'b0);
    queue_word(16'h0000, 1'b0);
    queue_word(16'h1234, 1'b0);
    queue_word(16'hFFFF, 1'b1);
    queue_word(16'h0000, 1'b0);
    wait_drained();

    set_range_limit(16'h0001);
    queue_word(16'h0001, 1'b1);
    queue_word(16'h0000, 1'b0);
    queue_word(16'h0002, 1'b0);
    queue_word(16'h0001, 1'b0);
    wait_drained();

    // Distance exactly at the limit stays in, one past it falls out.
    set_range_limit(16'h0100);
    queue_word(16'h1000, 1'b1);
    queue_word(16'h1100, 1'b0);
    queue_word(16'h1101, 1'b0);
    queue_word(16'h1000, 1'b0);
    queue_word(16'hFFFF, 1'b0);
    wait_drained();

    // One sequence long enough to fill the window and keep dropping samples.
    set_range_limit(16'hFFFF);
    queue_word(SAMPLE_W'($urandom_range(65535, 0)), 1'b1);
    for (int i = 1; i < DEPTH + 16; i++)
      queue_word(SAMPLE_W'($urandom_range(65535, 0)), 1'b0);
    wait_drained();

    foreach (limits[p]) begin
      set_range_limit(limits[p]);
      steady = (p == 3);
      queue_banded(60);
      wait_drained();
    end
    steady = 1'b0;

    repeat (DEPTH + 8) @(negedge clk);
    if (error_count == 0 && expected_lengths.size() == 0) begin
      $display("longest_bounded_range_window_core test passed");
    end else begin
      $display("longest_bounded_range_window_core test failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("longest_bounded_range_window_core test failed");
    $finish;
  end

endmodule
